>>> src/rarmt_pkg.sv
// Package for the range-add / range-max segment tree block.
// Holds sizes, command codes, sequencer states and a shared helper.
// No dependencies.
package rarmt_pkg;

  localparam int LEAVES  = 1024;
  localparam int LOG2    = $clog2(LEAVES);
  localparam int IDX_W   = LOG2;
  localparam int FIELD_W = 10;
  localparam int NODES   = 2 * LEAVES - 1;
  localparam int ADDR_W  = $clog2(NODES);
  localparam int DEP_W   = $clog2(LOG2 + 1);
  localparam int VAL_W   = 48;
  localparam int AMT_W   = 32;
  localparam int CAP_W   = 31;
  localparam int CMP_W   = VAL_W + 1;

  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_ADD     = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_QUERY,
    MODE_ADD,
    MODE_LOAD
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_RET,
    ST_UP_RD,
    ST_UP_EVAL,
    ST_CHECK,
    ST_RESULT
  } state_t;

  // signed maximum of two 48-bit words
  function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

>>> src/range_add_range_max_tree_core.sv
// Range-add / range-max segment tree: sequencer, node memories, output register.
// Depends on rarmt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per command, with fields
//   command, range_first, range_last, amount. Output channel (out_valid /
//   out_stall): one word per command with max_value and accepted.
//   Config channel (cfg_valid / cfg_ready): writes capacity_limit; cfg_ready
//   is always high. Write it only while the block is idle.
// Sequencing:
//   One command at a time. A node that ends the descent is read, evaluated
//   and returned; an inner node is read and evaluated, then read again,
//   combined and returned on the way up. An empty range goes straight to the
//   result; a query or load takes one pass, an add two, a reserve two if it
//   fits the capacity limit, else one. The next word is taken the cycle after
//   the result has moved to the output register.
// Reset:
//   rst (synchronous) starts a clearing pass that zeroes all 2047 node
//   entries, one per cycle; in_stall stays high until the pass ends.
// Stall: a held result sits in the output register; the next word runs meanwhile.
module range_add_range_max_tree_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic [rarmt_pkg::FIELD_W-1:0]       range_first,
  input  logic [rarmt_pkg::FIELD_W-1:0]       range_last,
  input  logic signed [rarmt_pkg::AMT_W-1:0]  amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rarmt_pkg::VAL_W-1:0]  max_value,
  output logic                                accepted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rarmt_pkg::CAP_W-1:0]         cfg_data
);

  localparam int VW = rarmt_pkg::VAL_W;
  localparam int AW = rarmt_pkg::ADDR_W;
  localparam int IW = rarmt_pkg::IDX_W;
  localparam int DW = rarmt_pkg::DEP_W;
  localparam int EW = (rarmt_pkg::FIELD_W > IW ? rarmt_pkg::FIELD_W : IW) + 1;

  // node memories, no reset: cleared by the sweep
  logic [VW-1:0] max_mem  [rarmt_pkg::NODES];
  logic [VW-1:0] pend_mem [rarmt_pkg::NODES];
  logic [VW-1:0] rd_max, rd_pend;

  // left-result stack, one entry per inner level
  logic [VW-1:0] acc [rarmt_pkg::LOG2];

  rarmt_pkg::state_t state, state_next;
  rarmt_pkg::mode_t  mode;
  rarmt_pkg::cmd_t   cmd;

  logic [AW-1:0]           clr_cnt;
  logic [AW-1:0]           pos;
  logic [IW-1:0]           lb;
  logic [DW-1:0]           depth;
  logic [IW-1:0]           rng_first, rng_last;
  logic [VW-1:0]           amt48, mx, ret_val;
  logic [rarmt_pkg::CAP_W-1:0] capacity_limit;
  logic                    res_acc;
  logic [VW-1:0]           res_max;

  // memory control
  logic          rd_en;
  logic          wr_max_en, wr_pend_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_max_data, wr_pend_data;

  // node geometry and classification
  logic [IW:0]   span, rb_ext, span_up;
  logic          node_in, node_out;
  logic [VW-1:0] total, eval_val, up_max, up_val;

  // input decode
  logic [EW-1:0] f_ext, l_ext, l_sat;
  logic          in_take, load_bad, rng_empty;
  logic          res_free, pass_done, fits;
  logic signed [rarmt_pkg::CMP_W-1:0] fit_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != rarmt_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign res_free  = !out_valid || !out_stall;

  assign f_ext     = EW'(range_first);
  assign l_ext     = EW'(range_last);
  assign l_sat     = (l_ext > EW'(rarmt_pkg::LEAVES - 1)) ? EW'(rarmt_pkg::LEAVES - 1) : l_ext;
  assign load_bad  = (f_ext >= EW'(rarmt_pkg::LEAVES));
  assign rng_empty = (f_ext > l_sat);

  assign span    = (IW + 1)'(rarmt_pkg::LEAVES) >> depth;
  assign span_up = span << 1;
  assign rb_ext  = {1'b0, lb} + span - (IW + 1)'(1);
  assign node_in  = (lb >= rng_first) && (rb_ext <= {1'b0, rng_last});
  assign node_out = (rb_ext < {1'b0, rng_first}) || (lb > rng_last);

  assign total  = rd_max + rd_pend;
  assign up_max = rarmt_pkg::smax(acc[depth], ret_val);
  assign up_val = up_max + rd_pend;

  always_comb begin
    eval_val = total;
    if (node_in) begin
      case (mode)
        rarmt_pkg::MODE_QUERY: eval_val = total;
        rarmt_pkg::MODE_ADD:   eval_val = total + amt48;
        rarmt_pkg::MODE_LOAD:  eval_val = amt48;
        default:               eval_val = total;
      endcase
    end else if (mode == rarmt_pkg::MODE_QUERY) begin
      eval_val = rarmt_pkg::NEG_MIN;
    end
  end

  assign pass_done = (state == rarmt_pkg::ST_RET) && (depth == '0);
  assign fit_sum   = $signed({mx[VW-1], mx}) +
                     $signed({{(rarmt_pkg::CMP_W - VW){amt48[VW-1]}}, amt48});
  assign fits      = (fit_sum <= $signed(rarmt_pkg::CMP_W'(capacity_limit)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rarmt_pkg::ST_CLEAR:
        if (clr_cnt == AW'(rarmt_pkg::NODES - 1)) state_next = rarmt_pkg::ST_IDLE;
      rarmt_pkg::ST_IDLE:
        if (in_take) begin
          if (command == rarmt_pkg::CMD_LOAD)
            state_next = load_bad ? rarmt_pkg::ST_RESULT : rarmt_pkg::ST_RD;
          else
            state_next = rng_empty ? rarmt_pkg::ST_RESULT : rarmt_pkg::ST_RD;
        end
      rarmt_pkg::ST_RD:   state_next = rarmt_pkg::ST_EVAL;
      rarmt_pkg::ST_EVAL:
        state_next = (node_in || node_out) ? rarmt_pkg::ST_RET : rarmt_pkg::ST_RD;
      rarmt_pkg::ST_RET:
        if (depth == '0) begin
          if (mode == rarmt_pkg::MODE_QUERY && cmd == rarmt_pkg::CMD_ADD)
            state_next = rarmt_pkg::ST_RD;
          else if (mode == rarmt_pkg::MODE_QUERY && cmd == rarmt_pkg::CMD_RESERVE)
            state_next = rarmt_pkg::ST_CHECK;
          else
            state_next = rarmt_pkg::ST_RESULT;
        end else begin
          state_next = pos[0] ? rarmt_pkg::ST_RD : rarmt_pkg::ST_UP_RD;
        end
      rarmt_pkg::ST_UP_RD:   state_next = rarmt_pkg::ST_UP_EVAL;
      rarmt_pkg::ST_UP_EVAL: state_next = rarmt_pkg::ST_RET;
      rarmt_pkg::ST_CHECK:   state_next = fits ? rarmt_pkg::ST_RD : rarmt_pkg::ST_RESULT;
      rarmt_pkg::ST_RESULT:  if (res_free) state_next = rarmt_pkg::ST_IDLE;
      default:               state_next = rarmt_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_en        = 1'b0;
    wr_max_en    = 1'b0;
    wr_pend_en   = 1'b0;
    wr_addr      = pos;
    wr_max_data  = '0;
    wr_pend_data = '0;
    case (state)
      rarmt_pkg::ST_CLEAR: begin
        wr_addr    = clr_cnt;
        wr_max_en  = 1'b1;
        wr_pend_en = 1'b1;
      end
      rarmt_pkg::ST_RD, rarmt_pkg::ST_UP_RD: rd_en = 1'b1;
      rarmt_pkg::ST_EVAL:
        if (node_in && mode == rarmt_pkg::MODE_ADD) begin
          wr_pend_en   = 1'b1;
          wr_pend_data = rd_pend + amt48;
        end else if (node_in && mode == rarmt_pkg::MODE_LOAD) begin
          wr_max_en    = 1'b1;
          wr_pend_en   = 1'b1;
          wr_max_data  = amt48;
          wr_pend_data = '0;
        end
      rarmt_pkg::ST_UP_EVAL:
        if (mode != rarmt_pkg::MODE_QUERY) begin
          wr_max_en   = 1'b1;
          wr_max_data = up_max;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_max  <= max_mem[pos];
      rd_pend <= pend_mem[pos];
    end
    if (wr_max_en)  max_mem[wr_addr]  <= wr_max_data;
    if (wr_pend_en) pend_mem[wr_addr] <= wr_pend_data;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rarmt_pkg::ST_CLEAR;
      clr_cnt        <= '0;
      capacity_limit <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rarmt_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (cfg_valid && cfg_ready) capacity_limit <= cfg_data;
      if (state == rarmt_pkg::ST_RESULT && res_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)              out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rarmt_pkg::ST_IDLE:
        if (in_take) begin
          cmd       <= rarmt_pkg::cmd_t'(command);
          amt48     <= VW'(amount);
          rng_first <= IW'(f_ext);
          rng_last  <= (command == rarmt_pkg::CMD_LOAD) ? IW'(f_ext) : IW'(l_sat);
          mode      <= (command == rarmt_pkg::CMD_LOAD) ? rarmt_pkg::MODE_LOAD
                                                        : rarmt_pkg::MODE_QUERY;
          pos       <= '0;
          lb        <= '0;
          depth     <= '0;
          mx        <= '0;
          res_acc   <= 1'b0;
          res_max   <= '0;
        end
      rarmt_pkg::ST_EVAL: begin
        ret_val <= eval_val;
        if (!node_in && !node_out) begin
          // descend into the left child
          pos   <= {pos[AW-2:0], 1'b1};
          depth <= depth + DW'(1);
        end
      end
      rarmt_pkg::ST_RET:
        if (depth == '0) begin
          if (mode == rarmt_pkg::MODE_QUERY) begin
            mx      <= ret_val;
            res_max <= ret_val;
            res_acc <= (cmd != rarmt_pkg::CMD_RESERVE);
            mode    <= rarmt_pkg::MODE_ADD;
          end else begin
            res_acc <= 1'b1;
          end
        end else if (pos[0]) begin
          // left done: hold its result, move to the right sibling
          acc[depth - DW'(1)] <= ret_val;
          pos <= pos + AW'(1);
          lb  <= lb + IW'(span);
        end else begin
          // right done: climb to the parent
          pos   <= (pos - AW'(1)) >> 1;
          depth <= depth - DW'(1);
          lb    <= lb & ~IW'(span_up - (IW + 1)'(1));
        end
      rarmt_pkg::ST_UP_EVAL: ret_val <= up_val;
      rarmt_pkg::ST_CHECK: begin
        res_acc <= fits;
        pos     <= '0;
        lb      <= '0;
        depth   <= '0;
      end
      default: ;
    endcase
    if (pass_done && mode == rarmt_pkg::MODE_QUERY) begin
      pos   <= '0;
      lb    <= '0;
      depth <= '0;
    end
    if (state == rarmt_pkg::ST_RESULT && res_free) begin
      max_value <= res_max;
      accepted  <= res_acc;
    end
  end

`ifndef SYNTHESIS
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == rarmt_pkg::ST_RD || state == rarmt_pkg::ST_UP_RD) |-> !wr_max_en && !wr_pend_en)
    else $error("node memory written during a read cycle");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state != rarmt_pkg::ST_CLEAR && state != rarmt_pkg::ST_IDLE) |->
      depth <= DW'(rarmt_pkg::LOG2))
    else $error("tree depth past the leaf level");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (state == rarmt_pkg::ST_RESULT && res_free) |=> out_valid)
    else $error("result not loaded into output register");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (mode == rarmt_pkg::MODE_QUERY && state != rarmt_pkg::ST_CLEAR) |-> !wr_max_en && !wr_pend_en)
    else $error("query pass modified the tree");
`endif

endmodule
